// File: sv/pthc_pkg.sv
// Shared types, constants and helper functions of the sensor compensation pipeline.
`timescale 1ns / 1ps

package pthc_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned IdxW   = 3;

  localparam logic [IdxW-1:0] REG_TEMP    = 3'd0;
  localparam logic [IdxW-1:0] REG_PRESS_A = 3'd1;
  localparam logic [IdxW-1:0] REG_PRESS_B = 3'd2;
  localparam logic [IdxW-1:0] REG_PRESS_C = 3'd3;
  localparam logic [IdxW-1:0] REG_HUM     = 3'd4;

  localparam logic [63:0] PressOffset = 64'd128000;
  localparam logic [20:0] PressFull   = 21'd1048576;
  localparam logic [63:0] PressScale  = 64'd3125;
  localparam logic [63:0] PressBias   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HumOffset   = 32'd76800;
  localparam logic [31:0] HumRound    = 32'd16384;
  localparam logic [31:0] HumHalf     = 32'd32768;
  localparam logic [31:0] HumBias     = 32'd2097152;
  localparam logic [31:0] HumRound2   = 32'd8192;
  localparam logic [31:0] HumMax      = 32'd419430400;
  localparam logic [31:0] TempRound   = 32'd128;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
    logic               press_invalid;
  } res_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        inv;
  } side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] s);
    return $signed(x) >>> s;
  endfunction

endpackage

// File: sv/pthc_mul64.sv
// Two-stage multiplier giving the low 64 bits of a 64 by 64 bit product.
`timescale 1ns / 1ps

module pthc_mul64 (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q;
  logic [31:0] hl_q;
  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    ll_q <= {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
    lh_q <= 32'(a_i[31:0] * b_i[63:32]);
    hl_q <= 32'(a_i[63:32] * b_i[31:0]);
    p_q  <= ll_q + {lh_q + hl_q, 32'b0};
  end

  assign p_o = p_q;

endmodule

// File: sv/pthc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps

module pthc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [63:0]           num_i,
  input  logic [63:0]           den_i,
  input  pthc_pkg::side_t       side_i,
  output logic                  vld_o,
  output logic [63:0]           quo_o,
  output pthc_pkg::side_t       side_o
);

  localparam int unsigned Steps = pthc_pkg::DataW;

  logic [Steps:0]  vld_q;
  logic [63:0]     rem_q  [Steps+1];
  logic [63:0]     dq_q   [Steps+1];
  logic [63:0]     den_q  [Steps+1];
  logic            neg_q  [Steps+1];
  pthc_pkg::side_t side_q [Steps+1];
  logic            out_vld_q;
  logic [63:0]     quo_q;
  pthc_pkg::side_t out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[Steps-1:0], vld_i};
      out_vld_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    dq_q[0]   <= num_i[63] ? 64'(0 - num_i) : num_i;
    den_q[0]  <= den_i[63] ? 64'(0 - den_i) : den_i;
    neg_q[0]  <= num_i[63] ^ den_i[63];
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [63:0] trial;
    logic        ge;
    assign trial = {rem_q[i][62:0], dq_q[i][63]};
    assign ge    = trial >= den_q[i];
    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= ge ? trial - den_q[i] : trial;
      dq_q[i+1]   <= {dq_q[i][62:0], ge};
      den_q[i+1]  <= den_q[i];
      neg_q[i+1]  <= neg_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= neg_q[Steps] ? 64'(0 - dq_q[Steps]) : dq_q[Steps];
    out_side_q <= side_q[Steps];
  end

  assign vld_o  = out_vld_q;
  assign quo_o  = quo_q;
  assign side_o = out_side_q;

endmodule

// File: sv/pth_sensor_compensation.sv
// Top level of the pressure, temperature and humidity compensation pipeline.
//
// Usage: calibration words are written through the APB port (64-bit data,
// register i at byte address 8*i) while no transaction is in flight. A
// measurement triple is taken on meas_i at each rising edge where start is
// high; busy is always low, so a new transaction may enter every cycle.
// Each transaction yields one result on res_o, shown for exactly one cycle
// with done_o high. Sustained throughput is one transaction per cycle. The
// latency is set mostly by the 64-stage signed divider for pressure, plus
// the two-stage 64-bit multipliers that build its operands and the final
// pressure correction.
// A zero pressure divisor gives zero pressure with press_invalid set.
// Reset clears all valid bits and sets every calibration word to zero; the
// pipeline then holds no transactions. The receiver cannot stall, so
// results are never held back.
`timescale 1ns / 1ps

module pth_sensor_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  pthc_pkg::meas_t                     meas_i,
  output logic                                done_o,
  output pthc_pkg::res_t                      res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pthc_pkg::AddrW-1:0]          paddr,
  input  logic [pthc_pkg::DataW-1:0]          pwdata,
  output logic [pthc_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned FrontN = 16;
  localparam int unsigned BackN  = 7;

  logic [47:0] temp_cal_q;
  logic [63:0] press_a_q;
  logic [63:0] press_b_q;
  logic [15:0] press_c_q;
  logic [63:0] hum_cal_q;
  logic [pthc_pkg::IdxW-1:0] reg_idx;

  assign reg_idx = paddr[pthc_pkg::AddrW-1:pthc_pkg::AddrW-pthc_pkg::IdxW];
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press_a_q  <= '0;
      press_b_q  <= '0;
      press_c_q  <= '0;
      hum_cal_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pthc_pkg::REG_TEMP:    temp_cal_q <= pwdata[47:0];
        pthc_pkg::REG_PRESS_A: press_a_q  <= pwdata;
        pthc_pkg::REG_PRESS_B: press_b_q  <= pwdata;
        pthc_pkg::REG_PRESS_C: press_c_q  <= pwdata[15:0];
        pthc_pkg::REG_HUM:     hum_cal_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pthc_pkg::REG_TEMP:    prdata = {16'b0, temp_cal_q};
      pthc_pkg::REG_PRESS_A: prdata = press_a_q;
      pthc_pkg::REG_PRESS_B: prdata = press_b_q;
      pthc_pkg::REG_PRESS_C: prdata = {48'b0, press_c_q};
      pthc_pkg::REG_HUM:     prdata = hum_cal_q;
      default:               prdata = '0;
    endcase
  end

  // Calibration fields.
  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'b0, temp_cal_q[15:0]};
  assign t2 = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
  assign t3 = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
  assign p1 = {48'b0, press_a_q[15:0]};
  assign p2 = {{48{press_a_q[31]}}, press_a_q[31:16]};
  assign p3 = {{48{press_a_q[47]}}, press_a_q[47:32]};
  assign p4 = {{48{press_a_q[63]}}, press_a_q[63:48]};
  assign p5 = {{48{press_b_q[15]}}, press_b_q[15:0]};
  assign p6 = {{48{press_b_q[31]}}, press_b_q[31:16]};
  assign p7 = {{48{press_b_q[47]}}, press_b_q[47:32]};
  assign p8 = {{48{press_b_q[63]}}, press_b_q[63:48]};
  assign p9 = {{48{press_c_q[15]}}, press_c_q};
  assign h1 = {24'b0, hum_cal_q[7:0]};
  assign h2 = {{16{hum_cal_q[23]}}, hum_cal_q[23:8]};
  assign h3 = {24'b0, hum_cal_q[31:24]};
  assign h4 = {{20{hum_cal_q[43]}}, hum_cal_q[43:32]};
  assign h5 = {{20{hum_cal_q[55]}}, hum_cal_q[55:44]};
  assign h6 = {{24{hum_cal_q[63]}}, hum_cal_q[63:56]};

  // Front pipeline: temperature, humidity and pressure divisor and dividend.
  logic [FrontN-1:0] vld_q;
  pthc_pkg::meas_t s0_meas_q, s1_meas_q, s2_meas_q, s3_meas_q, s4_meas_q, s5_meas_q;
  pthc_pkg::meas_t s6_meas_q;
  logic [31:0] s1_m1_q, s1_dd_q, s2_v1_q, s2_sq_q, s3_v1_q, s3_m2_q, s4_tf_q;
  logic [31:0] s5_temp_q, s6_temp_q, s7_temp_q, s8_temp_q, s9_temp_q, s10_temp_q;
  logic [31:0] s11_temp_q, s12_temp_q, s13_temp_q, s14_temp_q, s15_temp_q;
  logic [63:0] s5_a_q;
  logic [20:0] s5_base_q, s6_base_q, s7_base_q, s8_base_q, s9_base_q, s10_base_q;
  logic [31:0] s5_hv_q, s6_hx_q, s6_y1_q, s6_y2_q, s7_x_q, s7_ya_q, s7_yb_q;
  logic [31:0] s8_x_q, s8_ym_q, s9_x_q, s9_y_q, s10_x_q, s10_ym_q, s11_x_q, s11_y_q;
  logic [31:0] s12_v_q, s13_v_q, s13_ss_q, s14_v_q, s14_t_q;
  logic [16:0] s15_hum_q;
  logic [63:0] s8_ap5_q, s9_ap5_q, s8_ap2_q, s9_ap2_q;
  logic [63:0] s10_b_q, s10_a2p_q, s11_nb_q, s13_a3_q, s14_a3_q, s15_a3_q;
  logic [63:0] s14_num_q, s15_num_q;
  logic        s14_inv_q, s15_inv_q;

  logic [63:0] aa7, ap5_7, ap2_7, b1_9, aap3_9, a3p_12, num_13;
  logic [31:0] tf5, hum_v, hum_s, hum_cl;

  pthc_mul64 u_mul_aa  (.clk_i, .a_i(s5_a_q),    .b_i(s5_a_q),     .p_o(aa7));
  pthc_mul64 u_mul_ap5 (.clk_i, .a_i(s5_a_q),    .b_i(p5),         .p_o(ap5_7));
  pthc_mul64 u_mul_ap2 (.clk_i, .a_i(s5_a_q),    .b_i(p2),         .p_o(ap2_7));
  pthc_mul64 u_mul_b1  (.clk_i, .a_i(aa7),       .b_i(p6),         .p_o(b1_9));
  pthc_mul64 u_mul_aa3 (.clk_i, .a_i(aa7),       .b_i(p3),         .p_o(aap3_9));
  pthc_mul64 u_mul_a3  (.clk_i, .a_i(s10_a2p_q), .b_i(p1),         .p_o(a3p_12));
  pthc_mul64 u_mul_num (.clk_i, .a_i(s11_nb_q),  .b_i(pthc_pkg::PressScale), .p_o(num_13));

  assign tf5    = (s4_tf_q << 2) + s4_tf_q + pthc_pkg::TempRound;
  assign hum_s  = pthc_pkg::asr32(s12_v_q, 6'd15);
  assign hum_v  = s14_v_q - pthc_pkg::asr32(s14_t_q, 6'd4);
  assign hum_cl = hum_v[31] ? 32'd0 : ((hum_v > pthc_pkg::HumMax) ? pthc_pkg::HumMax : hum_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontN-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    s0_meas_q <= meas_i;
    // Temperature.
    s1_meas_q <= s0_meas_q;
    s1_m1_q   <= ({15'b0, s0_meas_q.raw_temp[19:3]} - {t1[30:0], 1'b0}) * t2;
    s1_dd_q   <= {16'b0, s0_meas_q.raw_temp[19:4]} - t1;
    s2_meas_q <= s1_meas_q;
    s2_v1_q   <= pthc_pkg::asr32(s1_m1_q, 6'd11);
    s2_sq_q   <= s1_dd_q * s1_dd_q;
    s3_meas_q <= s2_meas_q;
    s3_v1_q   <= s2_v1_q;
    s3_m2_q   <= pthc_pkg::asr32(s2_sq_q, 6'd12) * t3;
    s4_meas_q <= s3_meas_q;
    s4_tf_q   <= s3_v1_q + pthc_pkg::asr32(s3_m2_q, 6'd14);
    s5_meas_q <= s4_meas_q;
    s5_temp_q <= pthc_pkg::asr32(tf5, 6'd8);
    s5_a_q    <= {{32{s4_tf_q[31]}}, s4_tf_q} - pthc_pkg::PressOffset;
    s5_base_q <= pthc_pkg::PressFull - {1'b0, s4_meas_q.raw_press};
    s5_hv_q   <= s4_tf_q - pthc_pkg::HumOffset;
    // Humidity.
    s6_meas_q <= s5_meas_q;
    s6_hx_q   <= h5 * s5_hv_q;
    s6_y1_q   <= s5_hv_q * h6;
    s6_y2_q   <= s5_hv_q * h3;
    s7_x_q    <= pthc_pkg::asr32({2'b0, s6_meas_q.raw_hum, 14'b0} - {h4[11:0], 20'b0}
                                 - s6_hx_q + pthc_pkg::HumRound, 6'd15);
    s7_ya_q   <= pthc_pkg::asr32(s6_y1_q, 6'd10);
    s7_yb_q   <= pthc_pkg::asr32(s6_y2_q, 6'd11) + pthc_pkg::HumHalf;
    s8_x_q    <= s7_x_q;
    s8_ym_q   <= s7_ya_q * s7_yb_q;
    s9_x_q    <= s8_x_q;
    s9_y_q    <= pthc_pkg::asr32(s8_ym_q, 6'd10) + pthc_pkg::HumBias;
    s10_x_q   <= s9_x_q;
    s10_ym_q  <= s9_y_q * h2;
    s11_x_q   <= s10_x_q;
    s11_y_q   <= pthc_pkg::asr32(s10_ym_q + pthc_pkg::HumRound2, 6'd14);
    s12_v_q   <= s11_x_q * s11_y_q;
    s13_v_q   <= s12_v_q;
    s13_ss_q  <= hum_s * hum_s;
    s14_v_q   <= s13_v_q;
    s14_t_q   <= pthc_pkg::asr32(s13_ss_q, 6'd7) * h1;
    s15_hum_q <= hum_cl[28:12];
    // Temperature result carried along.
    s6_temp_q  <= s5_temp_q;
    s7_temp_q  <= s6_temp_q;
    s8_temp_q  <= s7_temp_q;
    s9_temp_q  <= s8_temp_q;
    s10_temp_q <= s9_temp_q;
    s11_temp_q <= s10_temp_q;
    s12_temp_q <= s11_temp_q;
    s13_temp_q <= s12_temp_q;
    s14_temp_q <= s13_temp_q;
    s15_temp_q <= s14_temp_q;
    // Pressure divisor and dividend.
    s6_base_q  <= s5_base_q;
    s7_base_q  <= s6_base_q;
    s8_base_q  <= s7_base_q;
    s9_base_q  <= s8_base_q;
    s10_base_q <= s9_base_q;
    s8_ap5_q   <= ap5_7;
    s9_ap5_q   <= s8_ap5_q;
    s8_ap2_q   <= ap2_7;
    s9_ap2_q   <= s8_ap2_q;
    s10_b_q    <= b1_9 + (s9_ap5_q << 17) + (p4 << 35);
    s10_a2p_q  <= pthc_pkg::asr64(aap3_9, 6'd8) + (s9_ap2_q << 12) + pthc_pkg::PressBias;
    s11_nb_q   <= ({43'b0, s10_base_q} << 31) - s10_b_q;
    s13_a3_q   <= pthc_pkg::asr64(a3p_12, 6'd33);
    s14_a3_q   <= s13_a3_q;
    s14_inv_q  <= (s13_a3_q == 64'd0);
    s14_num_q  <= num_13;
    s15_a3_q   <= s14_a3_q;
    s15_inv_q  <= s14_inv_q;
    s15_num_q  <= s14_num_q;
  end

  // Division.
  pthc_pkg::side_t div_side_in, div_side;
  logic            div_vld;
  logic [63:0]     div_quo;

  assign div_side_in = '{temp: s15_temp_q, hum: s15_hum_q, inv: s15_inv_q};

  pthc_div u_div (
    .clk_i,
    .rst_ni,
    .vld_i  (vld_q[FrontN-1]),
    .num_i  (s15_num_q),
    .den_i  (s15_a3_q),
    .side_i (div_side_in),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  // Back pipeline: pressure correction terms.
  logic [BackN-1:1] dv_q;
  logic [63:0]      d1_p_q, d2_p_q, d3_p_q, d4_p_q, d3_pb_q, d4_pb_q, d5_sum_q;
  pthc_pkg::side_t  d1_side_q, d2_side_q, d3_side_q, d4_side_q, d5_side_q;
  pthc_pkg::res_t   d6_res_q;
  logic [63:0]      qq_2, pb_2, pq_4, press_sum, press_val;

  pthc_mul64 u_mul_qq (.clk_i, .a_i(pthc_pkg::asr64(div_quo, 6'd13)),
                       .b_i(pthc_pkg::asr64(div_quo, 6'd13)), .p_o(qq_2));
  pthc_mul64 u_mul_pb (.clk_i, .a_i(p8), .b_i(div_quo), .p_o(pb_2));
  pthc_mul64 u_mul_pq (.clk_i, .a_i(p9), .b_i(qq_2),    .p_o(pq_4));

  assign press_sum = d4_p_q + pthc_pkg::asr64(pq_4, 6'd25) + pthc_pkg::asr64(d4_pb_q, 6'd19);
  assign press_val = pthc_pkg::asr64(d5_sum_q, 6'd8) + (p7 << 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[BackN-2:1], div_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    d1_p_q    <= div_quo;
    d2_p_q    <= d1_p_q;
    d3_p_q    <= d2_p_q;
    d4_p_q    <= d3_p_q;
    d3_pb_q   <= pb_2;
    d4_pb_q   <= d3_pb_q;
    d5_sum_q  <= press_sum;
    d1_side_q <= div_side;
    d2_side_q <= d1_side_q;
    d3_side_q <= d2_side_q;
    d4_side_q <= d3_side_q;
    d5_side_q <= d4_side_q;
    d6_res_q.temp_centi    <= d5_side_q.temp;
    d6_res_q.press_q24_8   <= d5_side_q.inv ? 32'd0 : press_val[31:0];
    d6_res_q.hum_q22_10    <= d5_side_q.hum;
    d6_res_q.press_invalid <= d5_side_q.inv;
  end

  assign done_o = dv_q[BackN-1];
  assign res_o  = d6_res_q;

endmodule
